>>> sv/ccfp_pkg.sv
// Shared widths, types and helpers for the circumcircle core.
package ccfp_pkg;

    localparam int COORD_BITS       = 12;
    localparam int RADIUS_FRAC_BITS = 8;

    localparam int CENTER_W = 17;
    localparam int RADIUS_W = 24;
    localparam int STATUS_W = 2;

    localparam int DIFF_W   = COORD_BITS + 1;
    localparam int SUMSQ_W  = 2 * COORD_BITS + 1;
    localparam int CROSS_W  = 2 * COORD_BITS + 3;
    localparam int U_W      = CROSS_W + 1;
    localparam int NUM_W    = 3 * COORD_BITS + 4;
    localparam int DIST_W   = 2 * COORD_BITS + 1;
    localparam int PROD2_W  = 2 * DIST_W;
    localparam int L_W      = 3 * DIST_W;
    localparam int X_SH     = 2 + 2 * RADIUS_FRAC_BITS;
    localparam int XRAW_W   = L_W + X_SH;
    localparam int X_W      = XRAW_W + (XRAW_W % 2);
    localparam int ROOT_W   = X_W / 2;

    localparam int QUO_W    = RADIUS_W + 1;
    localparam int DVD_W    = (NUM_W > ROOT_W) ? NUM_W : ROOT_W;
    localparam int DCMP_W   = DVD_W + QUO_W;

    localparam int SQRT_LAT = ROOT_W + 1;
    localparam int DIV_LAT  = QUO_W + 1;

    localparam logic [QUO_W-1:0] CENTER_POS_LIM = QUO_W'((1 << (CENTER_W - 1)) - 1);
    localparam logic [QUO_W-1:0] CENTER_NEG_LIM = QUO_W'(1 << (CENTER_W - 1));

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_COLLINEAR = 2'd1,
        ST_SAT       = 2'd2
    } status_t;

    typedef struct packed {
        logic coll;
        logic neg_x;
        logic neg_y;
    } side_t;

    typedef struct packed {
        logic [QUO_W-1:0] qx;
        logic             ovx;
        logic [QUO_W-1:0] qy;
        logic             ovy;
    } cen_t;

    typedef struct packed {
        logic [CENTER_W-1:0] val;
        logic                sat;
    } clamp_t;

    function automatic clamp_t clamp_center(input logic [QUO_W-1:0] q,
                                            input logic over,
                                            input logic neg);
        clamp_t r;
        r.sat = over | (neg ? (q > CENTER_NEG_LIM) : (q > CENTER_POS_LIM));
        if (r.sat)
            r.val = neg ? {1'b1, {(CENTER_W-1){1'b0}}} : {1'b0, {(CENTER_W-1){1'b1}}};
        else
            r.val = neg ? (-q[CENTER_W-1:0]) : q[CENTER_W-1:0];
        return r;
    endfunction

endpackage

>>> sv/circumcircle_from_three_points_core.sv
// Circumcircle core top level: front pipeline, dividers, square root and result stage.
// One item is taken every clock cycle and busy never rises.
// Each result passes the front pipeline, the one-bit-per-stage square root of
// the radius radicand, the 25-stage radius divider and the result register in
// that order; done pulses for one cycle per item with the result ports valid;
// results cannot be held off by the receiver and there is no need to.
module circumcircle_from_three_points_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [ccfp_pkg::COORD_BITS-1:0]       ax,
    input  logic [ccfp_pkg::COORD_BITS-1:0]       ay,
    input  logic [ccfp_pkg::COORD_BITS-1:0]       bx,
    input  logic [ccfp_pkg::COORD_BITS-1:0]       by,
    input  logic [ccfp_pkg::COORD_BITS-1:0]       cx,
    input  logic [ccfp_pkg::COORD_BITS-1:0]       cy,
    output logic                                  done,
    output logic signed [ccfp_pkg::CENTER_W-1:0]  center_x,
    output logic signed [ccfp_pkg::CENTER_W-1:0]  center_y,
    output logic [ccfp_pkg::RADIUS_W-1:0]         radius_q8,
    output logic [ccfp_pkg::STATUS_W-1:0]         status
);
    localparam int SQRT_LAT = ccfp_pkg::SQRT_LAT;
    localparam int SIDE_LAT = ccfp_pkg::SQRT_LAT + ccfp_pkg::DIV_LAT;
    localparam int QUO_W    = ccfp_pkg::QUO_W;
    localparam int RADIUS_W = ccfp_pkg::RADIUS_W;
    localparam int CENTER_W = ccfp_pkg::CENTER_W;

    logic                          f_valid;
    ccfp_pkg::side_t               f_side;
    logic [ccfp_pkg::NUM_W-1:0]    f_mnx, f_mny;
    logic [ccfp_pkg::U_W-1:0]      f_mu;
    logic [ccfp_pkg::X_W-1:0]      f_x;

    logic                          s_valid;
    logic [ccfp_pkg::ROOT_W-1:0]   s_root;

    logic                          r_valid, r_over;
    logic [QUO_W-1:0]              r_quo;
    ccfp_pkg::cen_t                cen;

    ccfp_pkg::side_t               side_reg [0:SIDE_LAT-1];
    ccfp_pkg::cen_t                cen_reg  [0:SQRT_LAT-1];
    logic [ccfp_pkg::U_W-1:0]      mu_reg   [0:SQRT_LAT-1];

    logic                          done_reg;
    logic [CENTER_W-1:0]           cx_reg, cy_reg;
    logic [RADIUS_W-1:0]           rad_reg;
    ccfp_pkg::status_t             st_reg;

    ccfp_pkg::clamp_t              clx, cly;
    logic [QUO_W:0]                rnd;
    logic [QUO_W-1:0]              rad_n;
    logic                          rad_sat;
    ccfp_pkg::side_t               side_out;
    logic [CENTER_W-1:0]           cx_next, cy_next;
    logic [RADIUS_W-1:0]           rad_next;
    ccfp_pkg::status_t             st_next;

    assign busy = 1'b0;

    ccfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .ax        (ax),
        .ay        (ay),
        .bx        (bx),
        .by        (by),
        .cx        (cx),
        .cy        (cy),
        .out_valid (f_valid),
        .side      (f_side),
        .mag_nx    (f_mnx),
        .mag_ny    (f_mny),
        .mag_u     (f_mu),
        .x_sq      (f_x)
    );

    ccfp_udiv u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .dvd       (ccfp_pkg::DVD_W'(f_mnx)),
        .dvs       (f_mu),
        .out_valid (),
        .quo       (cen.qx),
        .over      (cen.ovx)
    );

    ccfp_udiv u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .dvd       (ccfp_pkg::DVD_W'(f_mny)),
        .dvs       (f_mu),
        .out_valid (),
        .quo       (cen.qy),
        .over      (cen.ovy)
    );

    ccfp_isqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .x         (f_x),
        .out_valid (s_valid),
        .root      (s_root)
    );

    ccfp_udiv u_div_r (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .dvd       (ccfp_pkg::DVD_W'(s_root)),
        .dvs       (mu_reg[SQRT_LAT-1]),
        .out_valid (r_valid),
        .quo       (r_quo),
        .over      (r_over)
    );

    // alignment lines
    always_ff @(posedge clk)
    begin
        side_reg[0] <= f_side;
        for (int i = 1; i < SIDE_LAT; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
        cen_reg[0] <= cen;
        mu_reg[0]  <= f_mu;
        for (int i = 1; i < SQRT_LAT; i++)
        begin
            cen_reg[i] <= cen_reg[i-1];
            mu_reg[i]  <= mu_reg[i-1];
        end
    end

    // round to nearest: n = (q + 1) / 2
    always_comb
    begin
        side_out = side_reg[SIDE_LAT-1];
        clx      = ccfp_pkg::clamp_center(cen_reg[SQRT_LAT-1].qx, cen_reg[SQRT_LAT-1].ovx,
                                          side_out.neg_x);
        cly      = ccfp_pkg::clamp_center(cen_reg[SQRT_LAT-1].qy, cen_reg[SQRT_LAT-1].ovy,
                                          side_out.neg_y);
        rnd      = {1'b0, r_quo} + (QUO_W + 1)'(1);
        rad_n    = rnd[QUO_W:1];
        rad_sat  = r_over | rad_n[QUO_W-1];
        if (side_out.coll)
        begin
            cx_next  = '0;
            cy_next  = '0;
            rad_next = '0;
            st_next  = ccfp_pkg::ST_COLLINEAR;
        end
        else
        begin
            cx_next  = clx.val;
            cy_next  = cly.val;
            rad_next = rad_sat ? {RADIUS_W{1'b1}} : rad_n[RADIUS_W-1:0];
            st_next  = (clx.sat | cly.sat | rad_sat) ? ccfp_pkg::ST_SAT : ccfp_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= r_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg  <= cx_next;
        cy_reg  <= cy_next;
        rad_reg <= rad_next;
        st_reg  <= st_next;
    end

    assign done      = done_reg;
    assign center_x  = cx_reg;
    assign center_y  = cy_reg;
    assign radius_q8 = rad_reg;
    assign status    = st_reg;

endmodule

>>> sv/ccfp_front.sv
// Front pipeline: differences, products, sums, magnitudes and the radius radicand.
module ccfp_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [ccfp_pkg::COORD_BITS-1:0]    ax,
    input  logic [ccfp_pkg::COORD_BITS-1:0]    ay,
    input  logic [ccfp_pkg::COORD_BITS-1:0]    bx,
    input  logic [ccfp_pkg::COORD_BITS-1:0]    by,
    input  logic [ccfp_pkg::COORD_BITS-1:0]    cx,
    input  logic [ccfp_pkg::COORD_BITS-1:0]    cy,
    output logic                               out_valid,
    output ccfp_pkg::side_t                    side,
    output logic [ccfp_pkg::NUM_W-1:0]         mag_nx,
    output logic [ccfp_pkg::NUM_W-1:0]         mag_ny,
    output logic [ccfp_pkg::U_W-1:0]           mag_u,
    output logic [ccfp_pkg::X_W-1:0]           x_sq
);
    localparam int C       = ccfp_pkg::COORD_BITS;
    localparam int DIFF_W  = ccfp_pkg::DIFF_W;
    localparam int SUMSQ_W = ccfp_pkg::SUMSQ_W;
    localparam int CROSS_W = ccfp_pkg::CROSS_W;
    localparam int U_W     = ccfp_pkg::U_W;
    localparam int NUM_W   = ccfp_pkg::NUM_W;
    localparam int DIST_W  = ccfp_pkg::DIST_W;
    localparam int SD_W    = DIST_W + 1;
    localparam int PROD2_W = ccfp_pkg::PROD2_W;
    localparam int L_W     = ccfp_pkg::L_W;
    localparam int X_W     = ccfp_pkg::X_W;
    localparam int X_SH    = ccfp_pkg::X_SH;

    logic [5:1] vld_reg;

    // stage 1
    logic [C-1:0]              ax1_reg, bx1_reg, cx1_reg;
    logic signed [DIFF_W-1:0]  e1_reg, e2_reg, e3_reg, f1_reg, f2_reg, f3_reg;
    logic [SUMSQ_W-1:0]        sa_reg, sb_reg, sc_reg;
    // stage 2
    logic signed [CROSS_W-1:0] p1_reg, p2_reg, p3_reg;
    logic signed [NUM_W-1:0]   n1_reg, n2_reg, n3_reg, m1_reg, m2_reg, m3_reg;
    logic [DIST_W-1:0]         ab_reg, bc_reg, ca2_reg;
    // stage 3
    logic signed [U_W-1:0]     u_reg;
    logic signed [NUM_W-1:0]   nx_reg, ny_reg;
    logic [PROD2_W-1:0]        d12_reg;
    logic [DIST_W-1:0]         ca3_reg;
    // stage 4
    ccfp_pkg::side_t           side4_reg;
    logic [NUM_W-1:0]          mnx4_reg, mny4_reg;
    logic [U_W-1:0]            mu4_reg;
    logic [PROD2_W-1:0]        plo_reg, phi_reg;
    // stage 5
    ccfp_pkg::side_t           side5_reg;
    logic [NUM_W-1:0]          mnx5_reg, mny5_reg;
    logic [U_W-1:0]            mu5_reg;
    logic [X_W-1:0]            x5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[4:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        ax1_reg <= ax;
        bx1_reg <= bx;
        cx1_reg <= cx;
        e1_reg  <= $signed({1'b0, by}) - $signed({1'b0, cy});
        e2_reg  <= $signed({1'b0, cy}) - $signed({1'b0, ay});
        e3_reg  <= $signed({1'b0, ay}) - $signed({1'b0, by});
        f1_reg  <= $signed({1'b0, cx}) - $signed({1'b0, bx});
        f2_reg  <= $signed({1'b0, ax}) - $signed({1'b0, cx});
        f3_reg  <= $signed({1'b0, bx}) - $signed({1'b0, ax});
        sa_reg  <= SUMSQ_W'(ax) * SUMSQ_W'(ax) + SUMSQ_W'(ay) * SUMSQ_W'(ay);
        sb_reg  <= SUMSQ_W'(bx) * SUMSQ_W'(bx) + SUMSQ_W'(by) * SUMSQ_W'(by);
        sc_reg  <= SUMSQ_W'(cx) * SUMSQ_W'(cx) + SUMSQ_W'(cy) * SUMSQ_W'(cy);

        p1_reg  <= CROSS_W'($signed({1'b0, ax1_reg})) * CROSS_W'(e1_reg);
        p2_reg  <= CROSS_W'($signed({1'b0, bx1_reg})) * CROSS_W'(e2_reg);
        p3_reg  <= CROSS_W'($signed({1'b0, cx1_reg})) * CROSS_W'(e3_reg);
        n1_reg  <= NUM_W'($signed({1'b0, sa_reg})) * NUM_W'(e1_reg);
        n2_reg  <= NUM_W'($signed({1'b0, sb_reg})) * NUM_W'(e2_reg);
        n3_reg  <= NUM_W'($signed({1'b0, sc_reg})) * NUM_W'(e3_reg);
        m1_reg  <= NUM_W'($signed({1'b0, sa_reg})) * NUM_W'(f1_reg);
        m2_reg  <= NUM_W'($signed({1'b0, sb_reg})) * NUM_W'(f2_reg);
        m3_reg  <= NUM_W'($signed({1'b0, sc_reg})) * NUM_W'(f3_reg);
        ab_reg  <= DIST_W'(SD_W'(f3_reg) * SD_W'(f3_reg) + SD_W'(e3_reg) * SD_W'(e3_reg));
        bc_reg  <= DIST_W'(SD_W'(f1_reg) * SD_W'(f1_reg) + SD_W'(e1_reg) * SD_W'(e1_reg));
        ca2_reg <= DIST_W'(SD_W'(f2_reg) * SD_W'(f2_reg) + SD_W'(e2_reg) * SD_W'(e2_reg));

        u_reg   <= (U_W'(p1_reg) + U_W'(p2_reg) + U_W'(p3_reg)) <<< 1;
        nx_reg  <= n1_reg + n2_reg + n3_reg;
        ny_reg  <= m1_reg + m2_reg + m3_reg;
        d12_reg <= PROD2_W'(ab_reg) * PROD2_W'(bc_reg);
        ca3_reg <= ca2_reg;

        side4_reg.coll  <= (u_reg == '0);
        side4_reg.neg_x <= nx_reg[NUM_W-1] ^ u_reg[U_W-1];
        side4_reg.neg_y <= ny_reg[NUM_W-1] ^ u_reg[U_W-1];
        mnx4_reg <= nx_reg[NUM_W-1] ? NUM_W'(-nx_reg) : NUM_W'(nx_reg);
        mny4_reg <= ny_reg[NUM_W-1] ? NUM_W'(-ny_reg) : NUM_W'(ny_reg);
        mu4_reg  <= u_reg[U_W-1] ? U_W'(-u_reg) : U_W'(u_reg);
        plo_reg  <= PROD2_W'(d12_reg[DIST_W-1:0]) * PROD2_W'(ca3_reg);
        phi_reg  <= PROD2_W'(d12_reg[PROD2_W-1:DIST_W]) * PROD2_W'(ca3_reg);

        side5_reg <= side4_reg;
        mnx5_reg  <= mnx4_reg;
        mny5_reg  <= mny4_reg;
        mu5_reg   <= mu4_reg;
        x5_reg    <= X_W'((L_W'(phi_reg) << DIST_W) + L_W'(plo_reg)) << X_SH;
    end

    assign out_valid = vld_reg[5];
    assign side      = side5_reg;
    assign mag_nx    = mnx5_reg;
    assign mag_ny    = mny5_reg;
    assign mag_u     = mu5_reg;
    assign x_sq      = x5_reg;

endmodule

>>> sv/ccfp_isqrt.sv
// Pipelined integer square root, one root bit per stage.
module ccfp_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [ccfp_pkg::X_W-1:0]      x,
    output logic                          out_valid,
    output logic [ccfp_pkg::ROOT_W-1:0]   root
);
    localparam int X_W    = ccfp_pkg::X_W;
    localparam int ROOT_W = ccfp_pkg::ROOT_W;

    logic              vld_reg  [0:ROOT_W];
    logic [X_W-1:0]    rem_reg  [0:ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= x;
        root_reg[0] <= '0;
    end

    for (genvar k = 1; k <= ROOT_W; k++)
    begin : g_step
        localparam int B = ROOT_W - k;
        logic [X_W-1:0] trial;
        logic           take;

        // rem holds x minus root squared
        assign trial = (X_W'(root_reg[k-1]) << (B + 1)) + (X_W'(1) << (2 * B));
        assign take  = rem_reg[k-1] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            root_reg[k] <= root_reg[k-1] | (take ? (ROOT_W'(1) << B) : '0);
        end

        if (k < ROOT_W)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                rem_reg[k] <= take ? (rem_reg[k-1] - trial) : rem_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W];
    assign root      = root_reg[ROOT_W];

endmodule

>>> sv/ccfp_udiv.sv
// Pipelined unsigned restoring divider with quotient overflow flag.
module ccfp_udiv (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [ccfp_pkg::DVD_W-1:0]    dvd,
    input  logic [ccfp_pkg::U_W-1:0]      dvs,
    output logic                          out_valid,
    output logic [ccfp_pkg::QUO_W-1:0]    quo,
    output logic                          over
);
    localparam int DVD_W  = ccfp_pkg::DVD_W;
    localparam int U_W    = ccfp_pkg::U_W;
    localparam int QUO_W  = ccfp_pkg::QUO_W;
    localparam int DCMP_W = ccfp_pkg::DCMP_W;

    logic             vld_reg  [0:QUO_W];
    logic             over_reg [0:QUO_W];
    logic [DVD_W-1:0] rem_reg  [0:QUO_W-1];
    logic [U_W-1:0]   dvs_reg  [0:QUO_W-1];
    logic [QUO_W-1:0] q_reg    [0:QUO_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        over_reg[0] <= DCMP_W'(dvd) >= (DCMP_W'(dvs) << QUO_W);
        rem_reg[0]  <= dvd;
        dvs_reg[0]  <= dvs;
        q_reg[0]    <= '0;
    end

    for (genvar k = 1; k <= QUO_W; k++)
    begin : g_step
        localparam int B = QUO_W - k;
        logic [DCMP_W-1:0] trial;
        logic              take;

        assign trial = DCMP_W'(dvs_reg[k-1]) << B;
        assign take  = DCMP_W'(rem_reg[k-1]) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            over_reg[k] <= over_reg[k-1];
            q_reg[k]    <= q_reg[k-1] | (take ? (QUO_W'(1) << B) : '0);
        end

        if (k < QUO_W)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                rem_reg[k] <= take ? (rem_reg[k-1] - trial[DVD_W-1:0]) : rem_reg[k-1];
                dvs_reg[k] <= dvs_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[QUO_W];
    assign quo       = q_reg[QUO_W];
    assign over      = over_reg[QUO_W];

endmodule
